// ===== hw/rtl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared widths, character codes and the stage word type for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W         = 32;
	localparam int CHAR_W          = 6;
	localparam int NUM_DIGITS      = 10;
	localparam int DIGIT_W         = 4;
	localparam int DIGIT_IDX_W     = 4;
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	// one word in flight through the double-dabble stages
	typedef struct packed {
		logic                                neg;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd;
		logic [VALUE_W-1:0]                  bin;
	} dabble_t;

endpackage

// ===== hw/rtl/sitda_dabble.sv =====
// ----------------------------------------------------------------------------
// sitda_dabble
// Eight shift-and-add-3 steps of the binary to BCD conversion; the bits of
// the binary magnitude move out at the top into the BCD digits.
// ----------------------------------------------------------------------------
module sitda_dabble (
	input  sitda_pkg::dabble_t d_in,
	output sitda_pkg::dabble_t d_out
);

	always_comb begin
		logic [sitda_pkg::NUM_DIGITS-1:0][sitda_pkg::DIGIT_W-1:0] b;
		logic [sitda_pkg::VALUE_W-1:0]                            m;
		b = d_in.bcd;
		m = d_in.bin;
		for (int s = 0; s < sitda_pkg::STEPS_PER_STAGE; s++) begin
			for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
				if (b[d] >= 4'd5) begin
					b[d] = b[d] + 4'd3;
				end
			end
			{b, m} = {b, m} << 1;
		end
		d_out.neg = d_in.neg;
		d_out.bcd = b;
		d_out.bin = m;
	end

endmodule

// ===== hw/rtl/sitda_serialiser.sv =====
// ----------------------------------------------------------------------------
// sitda_serialiser
// Holds one converted number and hands out its characters one per word:
// the sign if negative, then the digits from the leading non-zero one down.
// ----------------------------------------------------------------------------
module sitda_serialiser (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     in_valid,
	output logic                                                     in_ready,
	input  logic                                                     in_neg,
	input  logic [sitda_pkg::NUM_DIGITS-1:0][sitda_pkg::DIGIT_W-1:0] in_bcd,
	output logic                                                     out_valid,
	input  logic                                                     out_ready,
	output logic [sitda_pkg::CHAR_W-1:0]                             char_code,
	output logic                                                     last
);

	logic                                                     busy_q;
	logic                                                     sign_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]                        idx_q;
	logic [sitda_pkg::NUM_DIGITS-1:0][sitda_pkg::DIGIT_W-1:0] bcd_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]                        lead_idx;
	logic                                                     load;
	logic                                                     take;

	// leading non-zero digit, zero gives digit 0 alone
	always_comb begin
		lead_idx = '0;
		for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
			if (in_bcd[d] != 4'd0) begin
				lead_idx = sitda_pkg::DIGIT_IDX_W'(d);
			end
		end
	end

	assign out_valid = busy_q;
	assign last      = !sign_q && (idx_q == '0);
	assign char_code = sign_q ? sitda_pkg::CHAR_MINUS
	                          : sitda_pkg::CHAR_ZERO + {2'b00, bcd_q[idx_q]};
	assign take      = busy_q && out_ready;
	assign in_ready  = !busy_q || (out_ready && last);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (take && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sign_q <= in_neg;
			idx_q  <= lead_idx;
			bcd_q  <= in_bcd;
		end else if (take) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (!last) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (char_code == sitda_pkg::CHAR_MINUS) ||
		           ((char_code >= sitda_pkg::CHAR_ZERO) &&
		            (char_code <= sitda_pkg::CHAR_ZERO + 6'd9)))
		else $error("character outside sign and digit codes");

	a_sign_once: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sign_q) |=> (busy_q && !sign_q))
		else $error("sign not followed by a digit");

	a_idx_down: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !sign_q && !last) |=> (busy_q && idx_q == $past(idx_q) - 1'b1))
		else $error("digit index did not step down");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q) |-> (take && last))
		else $error("number replaced before its last character");

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// Each accepted value comes out as 1 to 11 characters on the output channel,
// a leading '-' for negative values, no leading zeros, '0' for zero, and last
// high on the final character. The output serialiser sends one character a
// cycle while out_ready is high, and takes the next number as the last
// character of the one before leaves; the five-stage front end (sign and
// magnitude, then four stages of eight double-dabble steps) takes a new
// value every cycle while the serialiser keeps up, and the first character
// of a value appears after it has passed stages 1 to 5 and the serialiser.
module signed_int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sitda_pkg::CHAR_W-1:0]        char_code,
	output logic                                last
);

	sitda_pkg::dabble_t st_s1, st_s2, st_s3, st_s4, st_s5;
	sitda_pkg::dabble_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic               ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	logic               ser_ready;
	logic [sitda_pkg::VALUE_W-1:0] raw;

	// a stage may load when empty or when its word moves on
	assign ld_s5    = !vld_s5 || ser_ready;
	assign ld_s4    = !vld_s4 || ld_s5;
	assign ld_s3    = !vld_s3 || ld_s4;
	assign ld_s2    = !vld_s2 || ld_s3;
	assign ld_s1    = !vld_s1 || ld_s2;
	assign in_ready = ld_s1;

	// magnitude in unsigned form, so the most negative value needs no care
	assign raw       = value;
	assign nx_s1.neg = raw[sitda_pkg::VALUE_W-1];
	assign nx_s1.bcd = '0;
	assign nx_s1.bin = raw[sitda_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;

	sitda_dabble u_dabble_2 (.d_in(st_s1), .d_out(nx_s2));
	sitda_dabble u_dabble_3 (.d_in(st_s2), .d_out(nx_s3));
	sitda_dabble u_dabble_4 (.d_in(st_s3), .d_out(nx_s4));
	sitda_dabble u_dabble_5 (.d_in(st_s4), .d_out(nx_s5));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= in_valid;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
			if (ld_s4) vld_s4 <= vld_s3;
			if (ld_s5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) st_s1 <= nx_s1;
		if (ld_s2) st_s2 <= nx_s2;
		if (ld_s3) st_s3 <= nx_s3;
		if (ld_s4) st_s4 <= nx_s4;
		if (ld_s5) st_s5 <= nx_s5;
	end

	sitda_serialiser u_serialiser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_ready  (ser_ready),
		.in_neg    (st_s5.neg),
		.in_bcd    (st_s5.bcd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

endmodule
